// ===== hdl/tagged_serial_payload_deframer_defines.svh =====
// Assertion macros shared by the deframer checker.
// No dependencies; taken in by `include.
`ifndef TAGGED_SERIAL_PAYLOAD_DEFRAMER_DEFINES_SVH
`define TAGGED_SERIAL_PAYLOAD_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tspd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tspd: next-cycle check failed");

`endif

// ===== hdl/tspd_pkg.sv =====
// Constants and helpers for the tagged serial payload deframer.
// No dependencies; used by scoped names from the top level.
package tspd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned HdrCntW = 3;
  localparam int unsigned SpcCntW = 2;
  // Length accumulator before range check: len * 10 + digit
  localparam int unsigned AccW    = LenW + 4;

  localparam logic [LenW-1:0]    MaxPayload = 16'd65535;

  localparam logic [ByteW-1:0]   ChTag   = 8'h73;  // 's'
  localparam logic [ByteW-1:0]   ChSpace = 8'h20;  // ' '
  localparam logic [ByteW-1:0]   ChZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0]   ChNine  = 8'h39;  // '9'
  localparam logic [ByteW-1:0]   ChFour  = 8'h34;  // '4'

  localparam logic [HdrCntW-1:0] PosTag     = 3'd0;
  localparam logic [HdrCntW-1:0] PosPort    = 3'd1;
  localparam logic [HdrCntW-1:0] PosKwFirst = 3'd3;
  localparam logic [HdrCntW-1:0] PosKwLast  = 3'd6;
  localparam logic [HdrCntW-1:0] PosSat     = 3'd7;

  localparam logic [SpcCntW-1:0] SpcLength = 2'd2;
  localparam logic [SpcCntW-1:0] SpcDone   = 2'd3;

  // Characters of the "data" keyword
  function automatic logic [ByteW-1:0] keyword_char(input logic [1:0] idx);
    logic [ByteW-1:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h64;  // 'd'
      2'd1:    ch = 8'h61;  // 'a'
      2'd2:    ch = 8'h74;  // 't'
      default: ch = 8'h61;  // 'a'
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/tagged_serial_payload_deframer.sv =====
// Tagged serial payload deframer: header hunt, length check, payload pass-through.
// Depends on tspd_pkg.
//
// Usage
//   Slave channel: one received byte per transfer on s_axis_tdata.
//   Master channel: one result per transfer. m_axis_tdata is the payload byte,
//   m_axis_tlast marks the final byte of a frame, m_axis_tuser flags a header
//   whose length field was empty, non-numeric, zero or too large (tdata zero).
//   Frames are "s<port> data <len> " followed by <len> payload bytes; header
//   bytes and dropped bytes give no result.
// Pipeline and throughput
//   A byte taken in sits in the input register and is then decoded into the
//   result register, from which its result is offered on the master side.
//   One byte per cycle is sustained while the master side takes results; the
//   single decode stage between the two registers sets this.
// Reset
//   rst_ni empties both registers and clears the frame state; the block hunts a header.
// Stalls
//   With m_axis_tready low the result holds, the input register still fills,
//   and s_axis_tready drops only once both registers are occupied.
module tagged_serial_payload_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,   // frame_end
  output logic       m_axis_tuser    // [0] bad_length
);

  localparam int unsigned ByteW   = tspd_pkg::ByteW;
  localparam int unsigned LenW    = tspd_pkg::LenW;
  localparam int unsigned HdrCntW = tspd_pkg::HdrCntW;
  localparam int unsigned SpcCntW = tspd_pkg::SpcCntW;
  localparam int unsigned AccW    = tspd_pkg::AccW;

  // Input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // Frame state
  logic               in_payload_q, in_payload_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [SpcCntW-1:0] spc_cnt_q, spc_cnt_d;
  logic               tag_match_q, tag_match_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               len_ok_q, len_ok_d;
  logic [LenW-1:0]    left_q, left_d;

  // Result register
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_bad_q, out_bad_d;
  logic             res_valid;

  logic advance;
  logic in_xfer;

  // Decode helpers
  logic [ByteW-1:0] b;
  logic             is_digit;
  logic             kw_pos;
  logic             kw_hit;
  logic             drop;
  logic [AccW-1:0]  acc;
  logic [AccW-1:0]  len_ext;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign b        = in_byte_q;
  assign is_digit = (b >= tspd_pkg::ChZero) && (b <= tspd_pkg::ChNine);
  assign kw_pos   = (hdr_cnt_q >= tspd_pkg::PosKwFirst) && (hdr_cnt_q <= tspd_pkg::PosKwLast);
  assign kw_hit   = (b == tspd_pkg::keyword_char(2'(hdr_cnt_q - tspd_pkg::PosKwFirst)));
  assign len_ext  = {{(AccW-LenW){1'b0}}, len_q};
  // len * 10 + digit as two shifts and adds
  assign acc      = (len_ext << 3) + (len_ext << 1)
                  + {{(AccW-4){1'b0}}, 4'(b - tspd_pkg::ChZero)};

  // Tag, port and keyword checks
  always_comb begin
    drop = 1'b0;
    if ((hdr_cnt_q == tspd_pkg::PosTag) && (b != tspd_pkg::ChTag)) begin
      drop = 1'b1;
    end
    if ((hdr_cnt_q == tspd_pkg::PosPort) &&
        ((b < tspd_pkg::ChZero) || (b > tspd_pkg::ChFour))) begin
      drop = 1'b1;
    end
    if ((hdr_cnt_q == tspd_pkg::PosKwLast) && !(tag_match_q && kw_hit)) begin
      drop = 1'b1;
    end
  end

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    spc_cnt_d    = spc_cnt_q;
    tag_match_d  = tag_match_q;
    len_d        = len_q;
    len_ok_d     = len_ok_q;
    left_d       = left_q;
    res_valid    = 1'b0;
    out_byte_d   = b;
    out_last_d   = 1'b0;
    out_bad_d    = 1'b0;

    if (in_payload_q) begin
      res_valid  = 1'b1;
      out_last_d = (left_q <= LenW'(1));
      if (left_q <= LenW'(1)) begin
        in_payload_d = 1'b0;
        hdr_cnt_d    = '0;
        spc_cnt_d    = '0;
        tag_match_d  = 1'b1;
        len_d        = '0;
        len_ok_d     = 1'b1;
        left_d       = '0;
      end else begin
        left_d = left_q - LenW'(1);
      end
    end else if (drop) begin
      hdr_cnt_d   = '0;
      spc_cnt_d   = '0;
      tag_match_d = 1'b1;
      len_d       = '0;
      len_ok_d    = 1'b1;
      left_d      = '0;
    end else begin
      if (kw_pos && !kw_hit) begin
        tag_match_d = 1'b0;
      end
      if (hdr_cnt_q != tspd_pkg::PosSat) begin
        hdr_cnt_d = hdr_cnt_q + HdrCntW'(1);
      end

      if (b == tspd_pkg::ChSpace) begin
        spc_cnt_d = spc_cnt_q + SpcCntW'(1);
      end else if (spc_cnt_q == tspd_pkg::SpcLength) begin
        if (!is_digit) begin
          len_ok_d = 1'b0;
        end else if (len_ok_q) begin
          if (acc > {{(AccW-LenW){1'b0}}, tspd_pkg::MaxPayload}) begin
            len_ok_d = 1'b0;
          end else begin
            len_d = acc[LenW-1:0];
          end
        end
      end

      // Third space closes the header
      if (spc_cnt_d == tspd_pkg::SpcDone) begin
        if (!len_ok_d || (len_d == '0)) begin
          res_valid   = 1'b1;
          out_byte_d  = '0;
          out_bad_d   = 1'b1;
          hdr_cnt_d   = '0;
          spc_cnt_d   = '0;
          tag_match_d = 1'b1;
          len_d       = '0;
          len_ok_d    = 1'b1;
          left_d      = '0;
        end else begin
          left_d       = len_d;
          in_payload_d = 1'b1;
        end
      end
    end
  end

  // Control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      spc_cnt_q    <= '0;
      tag_match_q  <= 1'b1;
      len_q        <= '0;
      len_ok_q     <= 1'b1;
      left_q       <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (advance) begin
        in_payload_q <= in_payload_d;
        hdr_cnt_q    <= hdr_cnt_d;
        spc_cnt_q    <= spc_cnt_d;
        tag_match_q  <= tag_match_d;
        len_q        <= len_d;
        len_ok_q     <= len_ok_d;
        left_q       <= left_d;
      end
    end
  end

  // Data registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && res_valid) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
      out_bad_q  <= out_bad_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

// ===== hdl/tspd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends on tagged_serial_payload_deframer_defines.svh.
`include "tagged_serial_payload_deframer_defines.svh"

module tspd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  logic s_xfer;
  logic out_stall;

  assign s_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A stalled result holds its transfer
  `TSPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

  // Bad-length result carries a zero byte and no frame end
  `TSPD_ASSERT_IMPLY(a_bad_len_shape, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == 8'h00) && !m_axis_tlast)

  // A fresh result follows an earlier input transfer
  `TSPD_ASSERT_IMPLY(a_out_cause, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s_xfer, 2))

  // Input side is never refused while the output is free
  `TSPD_ASSERT_IMPLY(a_in_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

endmodule

bind tagged_serial_payload_deframer tspd_checker u_tspd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tagged_serial_payload_deframer_test.sv =====
// Self-checking bench for tagged_serial_payload_deframer: a stimulus table, a held-off frame, then random frames.
// Each result is checked against an in-bench deframer or a typed-in result and compared field by field.
// Depends on tspd_pkg and the deframer RTL.
module tagged_serial_payload_deframer_test;

  // Keyword that follows the port digit, first character in the top byte
  localparam logic [31:0] DataWord = "data";

  // How a stimulus row is checked: by the in-bench deframer, or by a typed-in result
  typedef enum logic [1:0] {
    ExpPredict,    // result, if any, comes from deframe_byte
    ExpNone,       // header or dropped byte, no result
    ExpBadLength,  // bad length result: tdata 0, tlast 0, tuser 1
    ExpFinal       // byte passes through with tlast set
  } row_check_e;

  typedef struct packed {
    logic [7:0] rx;
    row_check_e chk;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] payload;
    logic       frame_end;
    logic       bad_length;
  } deframed_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [7:0] payload_byte
  logic       m_axis_tlast;         // frame_end
  logic       m_axis_tuser;         // [0] bad_length

  row_check_e rx_check      = ExpPredict;  // check kind travelling with s_axis_tdata

  deframed_t  deframed_q[$];
  logic [7:0] burst_q[$];
  int         failures      = 0;
  int         send_gap_max  = 18;
  int         recv_gap_max  = 18;
  bit         hold_off_req  = 1'b0;

  // In-bench copy of the frame state
  logic        in_pay;
  logic [2:0]  hdr_pos;
  logic [1:0]  spc_seen;
  logic        kw_ok;
  logic [15:0] len_acc;
  logic        len_ok;
  logic [15:0] pay_left;

  tagged_serial_payload_deframer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Queue appends
  function automatic void expect_add(input deframed_t r);
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  function automatic void burst_add(input logic [7:0] b);
    burst_q.insert(burst_q.size(), b);
  endfunction

  function automatic void frame_clear();
    in_pay   = 1'b0;
    hdr_pos  = '0;
    spc_seen = '0;
    kw_ok    = 1'b1;
    len_acc  = '0;
    len_ok   = 1'b1;
    pay_left = '0;
  endfunction

  // Steps the frame state by one byte; returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output deframed_t res);
    logic [2:0]  pos;
    logic        drop;
    int unsigned acc;
    pos  = hdr_pos;
    drop = 1'b0;
    res  = '0;
    if (in_pay) begin
      res.payload   = b;
      res.frame_end = (pay_left <= 16'd1);
      if (pay_left <= 16'd1) frame_clear();
      else pay_left = pay_left - 16'd1;
      return 1'b1;
    end
    // header hunt: tag, port digit, then the keyword, judged on the seventh byte
    if (pos == tspd_pkg::PosTag && b != tspd_pkg::ChTag) drop = 1'b1;
    if (pos == tspd_pkg::PosPort && (b < tspd_pkg::ChZero || b > tspd_pkg::ChFour)) drop = 1'b1;
    if (pos >= tspd_pkg::PosKwFirst && pos <= tspd_pkg::PosKwLast &&
        b != DataWord[8 * (tspd_pkg::PosKwLast - pos) +: 8])
      kw_ok = 1'b0;
    if (pos == tspd_pkg::PosKwLast && !kw_ok) drop = 1'b1;
    if (drop) begin
      frame_clear();
      return 1'b0;
    end
    if (pos != tspd_pkg::PosSat) hdr_pos = pos + 3'd1;
    if (b == tspd_pkg::ChSpace) begin
      spc_seen = spc_seen + 2'd1;
    end else if (spc_seen == tspd_pkg::SpcLength) begin
      if (b >= tspd_pkg::ChZero && b <= tspd_pkg::ChNine) begin
        if (len_ok) begin
          acc = 32'(len_acc) * 10 + 32'(b - tspd_pkg::ChZero);
          if (acc > 32'(tspd_pkg::MaxPayload)) len_ok = 1'b0;
          else len_acc = acc[15:0];
        end
      end else begin
        len_ok = 1'b0;
      end
    end
    if (spc_seen == tspd_pkg::SpcDone) begin
      if (!len_ok || len_acc == '0) begin
        frame_clear();
        res.bad_length = 1'b1;
        return 1'b1;
      end
      pay_left = len_acc;
      in_pay   = 1'b1;
    end
    return 1'b0;
  endfunction

  // Scoreboard: input transfers feed the deframer, output transfers are checked.
  // Both are sampled in one process so neither depends on process order.
  always @(posedge clk_i) begin : scoreboard
    deframed_t got, want;
    bit        yields;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        yields = deframe_byte(s_axis_tdata, got);
        unique case (rx_check)
          ExpPredict:   if (yields) expect_add(got);
          ExpNone:      ;
          ExpBadLength: expect_add('{payload: 8'h00, frame_end: 1'b0, bad_length: 1'b1});
          ExpFinal:     expect_add('{payload: s_axis_tdata, frame_end: 1'b1,
                                     bad_length: 1'b0});
          default:      ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (deframed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %02h tlast %b tuser %b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          failures++;
        end else begin
          want = deframed_q.pop_front();
          if (m_axis_tdata !== want.payload) begin
            $display("%0t: payload_byte expected %02h, actual %02h",
                     $time, want.payload, m_axis_tdata);
            failures++;
          end
          if (m_axis_tlast !== want.frame_end) begin
            $display("%0t: frame_end expected %b, actual %b",
                     $time, want.frame_end, m_axis_tlast);
            failures++;
          end
          if (m_axis_tuser !== want.bad_length) begin
            $display("%0t: bad_length expected %b, actual %b",
                     $time, want.bad_length, m_axis_tuser);
            failures++;
          end
        end
      end
    end
  end

  // Receiver: a random stall before each result; a long hold-off when asked for
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        stall        = 200;
        hold_off_req = 1'b0;
      end else begin
        stall = $urandom_range(0, recv_gap_max);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // One input transfer. tvalid is only lowered when a gap follows, so that a
  // back-to-back byte never sees a low and a high in the same step.
  task automatic send_byte(input logic [7:0] b, input row_check_e chk);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    rx_check      <= chk;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender pause until every expected result is in, plus the pipeline depth
  task automatic await_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic void put_decimal(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) burst_add(digits[i]);
  endfunction

  // "s<port> data " with a random port digit
  function automatic void put_good_header();
    burst_add(tspd_pkg::ChTag);
    burst_add(8'(tspd_pkg::ChZero + $urandom_range(0, 4)));
    burst_add(tspd_pkg::ChSpace);
    for (int k = 3; k >= 0; k--) burst_add(DataWord[8 * k +: 8]);
    burst_add(tspd_pkg::ChSpace);
  endfunction

  // Random frame into burst_q; returns 1 unless the burst is plain line noise
  function automatic bit plan_random_frame();
    int unsigned sel, len;
    logic [7:0]  junk;
    burst_q.delete();
    sel = $urandom_range(0, 99);
    if (sel >= 90) begin
      // noise: often bytes that look like header material
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       burst_add(tspd_pkg::ChTag);
          1:       burst_add(tspd_pkg::ChSpace);
          2:       burst_add(8'(tspd_pkg::ChZero + $urandom_range(0, 9)));
          default: burst_add(8'($urandom_range(0, 255)));
        endcase
      end
      return 1'b0;
    end
    put_good_header();
    if (sel < 60) begin
      // well-formed, mostly short, now and then with leading zeros
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) burst_add(tspd_pkg::ChZero);
      put_decimal(len);
      burst_add(tspd_pkg::ChSpace);
      repeat (len) burst_add(8'($urandom_range(0, 255)));
    end else if (sel < 75) begin
      // bad length field
      case ($urandom_range(0, 5))
        0: ;  // empty
        1: repeat ($urandom_range(1, 3)) burst_add(tspd_pkg::ChZero);
        2: begin
          burst_add($urandom_range(0, 1) ? "-" : "+");
          put_decimal($urandom_range(1, 9));
        end
        3: begin
          put_decimal($urandom_range(1, 99));
          do junk = 8'($urandom_range(0, 255));
          while ((junk >= tspd_pkg::ChZero && junk <= tspd_pkg::ChNine) ||
                 junk == tspd_pkg::ChSpace);
          burst_add(junk);
          put_decimal($urandom_range(0, 9));
        end
        4: put_decimal($urandom_range(65536, 99999));
        default: put_decimal($urandom_range(100000, 32'hFFFF_FFFF));
      endcase
      burst_add(tspd_pkg::ChSpace);
    end else begin
      // broken header: one of the first seven bytes replaced
      burst_q[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
      len = $urandom_range(1, 4);
      put_decimal(len);
      burst_add(tspd_pkg::ChSpace);
      repeat (len) burst_add(8'($urandom_range(0, 255)));
    end
    return 1'b1;
  endfunction

  initial begin : stimulus
    stim_row_t steer_rows [22];
    int        framed_bytes;
    frame_clear();
    steer_rows = '{
      '{"x", ExpNone},                                       // bad tag, dropped
      '{"s", ExpNone}, '{"5", ExpNone},                      // bad port digit
      '{"s", ExpNone}, '{"4", ExpNone}, '{" ", ExpNone},     // bad keyword,
      '{"d", ExpNone}, '{"a", ExpNone}, '{"t", ExpNone},     // caught on the
      '{"x", ExpNone},                                       // seventh byte
      '{"s", ExpNone}, '{"0", ExpNone}, '{" ", ExpNone},     // early third space,
      '{" ", ExpNone}, '{" ", ExpBadLength},                 // empty length
      '{"s", ExpNone}, '{"3", ExpNone}, '{" ", ExpNone},     // early third space,
      '{" ", ExpNone}, '{"1", ExpNone}, '{" ", ExpNone},     // length one
      '{8'hFF, ExpFinal}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steer_rows[i]) send_byte(steer_rows[i].rx, steer_rows[i].chk);
    await_drain();

    // Receiver holds off while a back-to-back frame fills the block
    send_gap_max = 0;
    hold_off_req = 1'b1;
    put_good_header();
    put_decimal(40);
    burst_add(tspd_pkg::ChSpace);
    repeat (40) burst_add(8'($urandom_range(0, 255)));
    foreach (burst_q[i]) send_byte(burst_q[i], ExpPredict);
    burst_q.delete();
    await_drain();

    framed_bytes = 0;
    while (framed_bytes < 340) begin
      // about one frame in four runs with neither side idling
      if ($urandom_range(0, 3) == 0) begin
        send_gap_max = 0;
        recv_gap_max = 0;
      end else begin
        send_gap_max = 18;
        recv_gap_max = 18;
      end
      if (plan_random_frame()) framed_bytes += burst_q.size();
      foreach (burst_q[i]) send_byte(burst_q[i], ExpPredict);
      if ($urandom_range(0, 29) == 0) await_drain();
    end

    await_drain();
    if (failures == 0) begin
      $display("PASS tagged_serial_payload_deframer");
    end else begin
      $display("FAIL tagged_serial_payload_deframer");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("FAIL tagged_serial_payload_deframer");
    $finish;
  end

endmodule
